// ===== rtl/pmwp_pkg.sv =====
// ----------------------------------------------------------------------------
// Pulse meter windowed power - shared definitions
// Word formats, command codes, ring geometry and scaling constants.
// ----------------------------------------------------------------------------
package pmwp_pkg;

  // Ring geometry: one hour of samples
  localparam int unsigned SAMPLES_HOUR = 3600;
  localparam int unsigned WIN_LONG     = SAMPLES_HOUR / 5;
  localparam int unsigned WIN_MID      = SAMPLES_HOUR / 25;
  localparam int unsigned WIN_SHORT    = SAMPLES_HOUR / 100;
  localparam int unsigned ADDR_W       = $clog2(SAMPLES_HOUR);
  localparam int unsigned FILL_W       = $clog2(SAMPLES_HOUR + 1);

  // Field and datapath widths
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned EPT_W     = 8;
  localparam int unsigned SUM_L_W   = COUNT_W + $clog2(WIN_LONG + 1);
  localparam int unsigned SUM_M_W   = COUNT_W + $clog2(WIN_MID + 1);
  localparam int unsigned SUM_S_W   = COUNT_W + $clog2(WIN_SHORT + 1);
  localparam int unsigned ENERGY_W  = 40;
  localparam int unsigned SCALED_W  = 29;
  localparam int unsigned POW_W     = 37;
  localparam int unsigned MIDPOW_W  = 36;
  localparam int unsigned ETOT_W    = 48;
  localparam int unsigned DELTA_W   = 24;
  localparam int unsigned BAND_W    = 16;

  // Window scale factors and tolerance bands (per energy unit)
  localparam int unsigned SCALE_SHORT = 100;
  localparam int unsigned SCALE_MID   = 25;
  localparam int unsigned SCALE_LONG  = 5;
  localparam int unsigned BAND_FIRST  = 2 * 100;
  localparam int unsigned BAND_SECOND = 2 * 25;
  localparam int unsigned BAND_THIRD  = 2 * 5;

  typedef enum logic [1:0] {
    CmdSample      = 2'd0,
    CmdRestart     = 2'd1,
    CmdResetTotals = 2'd2,
    CmdTakeDelta   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    WinSelLong  = 2'd0,
    WinSelMid   = 2'd1,
    WinSelShort = 2'd2
  } win_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [COUNT_W-1:0] count_now;
  } in_word_t;

  typedef struct packed {
    logic signed [POW_W-1:0] power_estimate;
    logic [MIDPOW_W-1:0]     power_mid_window;
    logic [ETOT_W-1:0]       energy_total;
    logic [DELTA_W-1:0]      delta_steps;
  } out_word_t;

  // Request from the sequencer to the increment ring
  typedef struct packed {
    logic               rd_en;
    win_e               rd_win;
    logic               wr_en;
    logic [COUNT_W-1:0] wr_data;
  } ring_req_t;

endpackage

// ===== rtl/pmwp_ring.sv =====
// ----------------------------------------------------------------------------
// Pulse meter increment ring
// One-hour ring of tick increments with window look-back reads and a fill
// count that makes never-written entries read as zero.
// ----------------------------------------------------------------------------
module pmwp_ring (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pmwp_pkg::ring_req_t           req_i,
  output logic [pmwp_pkg::COUNT_W-1:0]  rd_data_o
);

  logic [pmwp_pkg::COUNT_W-1:0] mem [pmwp_pkg::SAMPLES_HOUR];

  logic [pmwp_pkg::ADDR_W-1:0] pos_q, pos_d;
  logic [pmwp_pkg::FILL_W-1:0] fill_q, fill_d;
  logic [pmwp_pkg::ADDR_W-1:0] span;
  logic [pmwp_pkg::ADDR_W-1:0] rd_addr;
  logic                        rd_hit;
  logic [pmwp_pkg::COUNT_W-1:0] rd_q;
  logic                        hit_q;

  always_comb begin
    case (req_i.rd_win)
      pmwp_pkg::WinSelLong:  span = pmwp_pkg::ADDR_W'(pmwp_pkg::WIN_LONG);
      pmwp_pkg::WinSelMid:   span = pmwp_pkg::ADDR_W'(pmwp_pkg::WIN_MID);
      pmwp_pkg::WinSelShort: span = pmwp_pkg::ADDR_W'(pmwp_pkg::WIN_SHORT);
      default:               span = pmwp_pkg::ADDR_W'(pmwp_pkg::WIN_SHORT);
    endcase
  end

  // Step back by the window length, wrapping around the ring
  always_comb begin
    if (pos_q >= span) begin
      rd_addr = pos_q - span;
    end else begin
      rd_addr = pos_q + (pmwp_pkg::ADDR_W'(pmwp_pkg::SAMPLES_HOUR) - span);
    end
    rd_hit = (fill_q >= pmwp_pkg::FILL_W'(span));
  end

  always_comb begin
    pos_d  = pos_q;
    fill_d = fill_q;
    if (req_i.wr_en) begin
      if (pos_q == pmwp_pkg::ADDR_W'(pmwp_pkg::SAMPLES_HOUR - 1)) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + 1'b1;
      end
      if (fill_q < pmwp_pkg::FILL_W'(pmwp_pkg::SAMPLES_HOUR)) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      fill_q <= '0;
    end else begin
      pos_q  <= pos_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[pos_q] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q  <= mem[rd_addr];
      hit_q <= rd_hit;
    end
  end

  assign rd_data_o = hit_q ? rd_q : '0;

endmodule

// ===== rtl/pulse_meter_windowed_power_top.sv =====
// ----------------------------------------------------------------------------
// Pulse meter windowed power - top level
// Turns meter counter readings into windowed power, energy and delta words.
// ----------------------------------------------------------------------------
// The block takes one command word at a time and returns exactly one result
// word per command. An add-sample word occupies the block from
// acceptance to the next possible acceptance: three look-back reads go one
// after another through the single read port of the 3600-entry increment
// ring (long, mid, short window), followed by a constant-scale stage, an
// energy-per-tick multiply stage and two band-compare stages. Restart,
// reset-totals, take-delta and the priming sample skip the ring. A
// finished result sits in an output register, so the next word
// is accepted while the previous result is still stalled. After reset the
// ring reads as all zero at once: a fill count masks entries not yet
// written, so there is no clearing pass. energy_per_tick may be written only
// while the block is idle.
// ----------------------------------------------------------------------------
module pulse_meter_windowed_power_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [pmwp_pkg::EPT_W-1:0]   cfg_wdata_i,
  // command words
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  pmwp_pkg::in_word_t           in_word_i,
  // result words
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output pmwp_pkg::out_word_t          out_word_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_LONG,
    ST_RD_MID,
    ST_RD_SHORT,
    ST_SCALE,
    ST_MUL,
    ST_SEL1,
    ST_SEL2
  } state_e;

  // Band test: next lies strictly inside (est - band, est + band)
  function automatic logic in_band(logic [pmwp_pkg::POW_W-1:0]  nxt,
                                   logic [pmwp_pkg::POW_W-1:0]  est,
                                   logic [pmwp_pkg::BAND_W-1:0] band);
    logic signed [pmwp_pkg::POW_W:0] diff;
    logic signed [pmwp_pkg::POW_W:0] bnd;
    diff = $signed({1'b0, nxt}) - $signed({1'b0, est});
    bnd  = $signed((pmwp_pkg::POW_W + 1)'(band));
    return (diff < bnd) && (-diff < bnd);
  endfunction

  state_e state_q, state_d;

  // Architectural state
  logic [pmwp_pkg::SUM_L_W-1:0]  sum_long_q, sum_long_d;
  logic [pmwp_pkg::SUM_M_W-1:0]  sum_mid_q, sum_mid_d;
  logic [pmwp_pkg::SUM_S_W-1:0]  sum_short_q, sum_short_d;
  logic [pmwp_pkg::ENERGY_W-1:0] energy_q, energy_d;
  logic [pmwp_pkg::COUNT_W-1:0]  prev_q, prev_d;
  logic [pmwp_pkg::COUNT_W-1:0]  mark_q, mark_d;
  logic                          priming_q, priming_d;
  logic [pmwp_pkg::EPT_W-1:0]    ept_q, ept_d;
  logic                          out_valid_q, out_valid_d;

  // Datapath words
  logic [pmwp_pkg::COUNT_W-1:0]  inc_q;
  logic [pmwp_pkg::COUNT_W-1:0]  delta_raw_q;
  logic [pmwp_pkg::SCALED_W-1:0] short_s_q, mid_s_q, long_s_q;
  logic [pmwp_pkg::POW_W-1:0]    p_short_q, p_mid_q, p_long_q;
  logic [pmwp_pkg::ETOT_W-1:0]   p_energy_q;
  logic [pmwp_pkg::DELTA_W-1:0]  p_delta_q;
  logic [pmwp_pkg::BAND_W-1:0]   band1_q, band2_q;
  logic [pmwp_pkg::POW_W-1:0]    est1_q;
  logic [pmwp_pkg::BAND_W-1:0]   est1_band_q;
  pmwp_pkg::out_word_t           out_word_q;

  logic                          in_accept;
  logic                          out_load;
  logic                          sel1_hit, sel2_hit;
  logic [pmwp_pkg::ENERGY_W:0]   energy_sum;
  pmwp_pkg::ring_req_t           ring_req;
  logic [pmwp_pkg::COUNT_W-1:0]  ring_rd_data;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  // Load the result once the output register is empty or being drained
  assign out_load   = (state_q == ST_SEL2) && (!out_valid_q || !out_stall_i);

  pmwp_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ring_req),
    .rd_data_o (ring_rd_data)
  );

  // Ring accesses: issue long read on acceptance, then mid and short; the
  // new increment is written as the last look-back is consumed.
  always_comb begin
    ring_req         = '0;
    ring_req.rd_win  = pmwp_pkg::WinSelLong;
    ring_req.wr_data = inc_q;
    case (state_q)
      ST_IDLE: begin
        ring_req.rd_en = in_accept && !priming_q &&
                         (pmwp_pkg::cmd_e'(in_word_i.cmd) == pmwp_pkg::CmdSample);
      end
      ST_RD_LONG: begin
        ring_req.rd_en  = 1'b1;
        ring_req.rd_win = pmwp_pkg::WinSelMid;
      end
      ST_RD_MID: begin
        ring_req.rd_en  = 1'b1;
        ring_req.rd_win = pmwp_pkg::WinSelShort;
      end
      ST_RD_SHORT: begin
        ring_req.wr_en = 1'b1;
      end
      default: begin
        ring_req.rd_en = 1'b0;
      end
    endcase
  end

  assign energy_sum = {1'b0, energy_q} + (pmwp_pkg::ENERGY_W + 1)'(inc_q);

  // Control and architectural state
  always_comb begin
    state_d     = state_q;
    sum_long_d  = sum_long_q;
    sum_mid_d   = sum_mid_q;
    sum_short_d = sum_short_q;
    energy_d    = energy_q;
    prev_d      = prev_q;
    mark_d      = mark_q;
    priming_d   = priming_q;
    ept_d       = ept_q;
    out_valid_d = out_valid_q;

    if (cfg_we_i) begin
      ept_d = cfg_wdata_i;
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_SCALE;
          case (pmwp_pkg::cmd_e'(in_word_i.cmd))
            pmwp_pkg::CmdSample: begin
              prev_d = in_word_i.count_now;
              if (priming_q) begin
                mark_d    = in_word_i.count_now;
                priming_d = 1'b0;
              end else begin
                state_d = ST_RD_LONG;
              end
            end
            pmwp_pkg::CmdRestart: begin
              priming_d = 1'b1;
            end
            pmwp_pkg::CmdResetTotals: begin
              energy_d = '0;
              mark_d   = prev_q;
            end
            default: begin
              mark_d = prev_q;
            end
          endcase
        end
      end
      ST_RD_LONG: begin
        sum_long_d = sum_long_q + pmwp_pkg::SUM_L_W'(inc_q)
                     - pmwp_pkg::SUM_L_W'(ring_rd_data);
        state_d    = ST_RD_MID;
      end
      ST_RD_MID: begin
        sum_mid_d = sum_mid_q + pmwp_pkg::SUM_M_W'(inc_q)
                    - pmwp_pkg::SUM_M_W'(ring_rd_data);
        state_d   = ST_RD_SHORT;
      end
      ST_RD_SHORT: begin
        sum_short_d = sum_short_q + pmwp_pkg::SUM_S_W'(inc_q)
                      - pmwp_pkg::SUM_S_W'(ring_rd_data);
        // Saturate the energy count at its full scale
        if (energy_sum[pmwp_pkg::ENERGY_W]) begin
          energy_d = '1;
        end else begin
          energy_d = energy_sum[pmwp_pkg::ENERGY_W-1:0];
        end
        state_d = ST_SCALE;
      end
      ST_SCALE: state_d = ST_MUL;
      ST_MUL:   state_d = ST_SEL1;
      ST_SEL1:  state_d = ST_SEL2;
      ST_SEL2: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_long_q  <= '0;
      sum_mid_q   <= '0;
      sum_short_q <= '0;
      energy_q    <= '0;
      prev_q      <= '0;
      mark_q      <= '0;
      priming_q   <= 1'b1;
      ept_q       <= pmwp_pkg::EPT_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_long_q  <= sum_long_d;
      sum_mid_q   <= sum_mid_d;
      sum_short_q <= sum_short_d;
      energy_q    <= energy_d;
      prev_q      <= prev_d;
      mark_q      <= mark_d;
      priming_q   <= priming_d;
      ept_q       <= ept_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Band selection: move to the mid window, then to the long window
  assign sel1_hit = in_band(p_mid_q, p_short_q, band1_q);
  assign sel2_hit = in_band(p_long_q, est1_q, est1_band_q);

  // Datapath pipeline
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      inc_q <= in_word_i.count_now - prev_q;
      if (pmwp_pkg::cmd_e'(in_word_i.cmd) == pmwp_pkg::CmdTakeDelta) begin
        delta_raw_q <= prev_q - mark_q;
      end else begin
        delta_raw_q <= '0;
      end
    end
    if (state_q == ST_SCALE) begin
      short_s_q <= pmwp_pkg::SCALED_W'(sum_short_q)
                   * pmwp_pkg::SCALED_W'(pmwp_pkg::SCALE_SHORT);
      mid_s_q   <= pmwp_pkg::SCALED_W'(sum_mid_q)
                   * pmwp_pkg::SCALED_W'(pmwp_pkg::SCALE_MID);
      long_s_q  <= pmwp_pkg::SCALED_W'(sum_long_q)
                   * pmwp_pkg::SCALED_W'(pmwp_pkg::SCALE_LONG);
    end
    if (state_q == ST_MUL) begin
      p_short_q  <= pmwp_pkg::POW_W'(short_s_q) * pmwp_pkg::POW_W'(ept_q);
      p_mid_q    <= pmwp_pkg::POW_W'(mid_s_q) * pmwp_pkg::POW_W'(ept_q);
      p_long_q   <= pmwp_pkg::POW_W'(long_s_q) * pmwp_pkg::POW_W'(ept_q);
      p_energy_q <= pmwp_pkg::ETOT_W'(energy_q) * pmwp_pkg::ETOT_W'(ept_q);
      p_delta_q  <= pmwp_pkg::DELTA_W'(delta_raw_q) * pmwp_pkg::DELTA_W'(ept_q);
      band1_q    <= pmwp_pkg::BAND_W'(ept_q) * pmwp_pkg::BAND_W'(pmwp_pkg::BAND_FIRST);
      band2_q    <= pmwp_pkg::BAND_W'(ept_q) * pmwp_pkg::BAND_W'(pmwp_pkg::BAND_SECOND);
    end
    // Tighten the band only after a move to the mid window
    if (state_q == ST_SEL1) begin
      est1_q      <= sel1_hit ? p_mid_q : p_short_q;
      est1_band_q <= sel1_hit ? band2_q : band1_q;
    end
    if (out_load) begin
      out_word_q.power_estimate   <= $signed(sel2_hit ? p_long_q : est1_q);
      out_word_q.power_mid_window <= p_mid_q[pmwp_pkg::MIDPOW_W-1:0];
      out_word_q.energy_total     <= p_energy_q;
      out_word_q.delta_steps      <= p_delta_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTHESIS
  // Nested windows: the short sum never exceeds the mid, nor the mid the long
  a_window_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pmwp_pkg::SUM_L_W'(sum_short_q) <= pmwp_pkg::SUM_L_W'(sum_mid_q)) &&
    (pmwp_pkg::SUM_L_W'(sum_mid_q) <= sum_long_q))
    else $error("window sums out of order");

  // A result appears only from the final select stage
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_SEL2))
    else $error("result word raised outside final select");

  // The ring is written only right after the short-window look-back
  a_ring_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_req.wr_en |-> ($past(state_q == ST_RD_MID) && !priming_q))
    else $error("ring write out of sequence");
`endif

endmodule
